/* hw/rtl/srcuv_pkg.sv */
// Package for the sprite rectangle clipper: constants, register indexes and shared types.
// Used by every module of the block but the divider; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package srcuv_pkg;
	localparam int UV_FRAC_BITS_DEF = 16;
	localparam int POS_W = 16;
	localparam int SIZE_W = 15;
	localparam int OSIZE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_ENABLE = 3'd0,
		REG_CLIP_LEFT   = 3'd1,
		REG_CLIP_TOP    = 3'd2,
		REG_CLIP_RIGHT  = 3'd3,
		REG_CLIP_BOTTOM = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic enable;
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic signed [POS_W-1:0] right;
		logic signed [POS_W-1:0] bottom;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [OSIZE_W-1:0] size_out;
		logic [SIZE_W-1:0]  size_in;
		logic [SIZE_W-1:0]  m1;
		logic [SIZE_W-1:0]  m2;
		logic               skip;
		logic               neg;
	} axis_geom_t;
endpackage
`default_nettype wire

/* hw/rtl/srcuv_if.sv */
// Handshake interfaces for the sprite input words and the result words.
// Depends on srcuv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface srcuv_in_if import srcuv_pkg::*; #(parameter int UVW = UV_FRAC_BITS_DEF + 1);
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [SIZE_W-1:0] size_w;
	logic [SIZE_W-1:0] size_h;
	logic [UVW-1:0] tex_u1;
	logic [UVW-1:0] tex_v1;
	logic [UVW-1:0] tex_u2;
	logic [UVW-1:0] tex_v2;
	modport source (output valid, pos_x, pos_y, size_w, size_h, tex_u1, tex_v1, tex_u2, tex_v2,
		input ready);
	modport sink (input valid, pos_x, pos_y, size_w, size_h, tex_u1, tex_v1, tex_u2, tex_v2,
		output ready);
endinterface

interface srcuv_out_if import srcuv_pkg::*; #(parameter int UVW = UV_FRAC_BITS_DEF + 1);
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] out_x;
	logic signed [POS_W-1:0] out_y;
	logic [OSIZE_W-1:0] out_w;
	logic [OSIZE_W-1:0] out_h;
	logic [UVW-1:0] out_u1;
	logic [UVW-1:0] out_v1;
	logic [UVW-1:0] out_u2;
	logic [UVW-1:0] out_v2;
	modport source (output valid, out_x, out_y, out_w, out_h, out_u1, out_v1, out_u2, out_v2,
		input ready);
	modport sink (input valid, out_x, out_y, out_w, out_h, out_u1, out_v1, out_u2, out_v2,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/srcuv_front.sv */
// Front stage: accepts sprite words, runs the inside test and the edge clamps.
// Depends on srcuv_pkg and srcuv_if; feeds the queue.
`timescale 1ns / 1ps
`default_nettype none
module srcuv_front import srcuv_pkg::*; #(
	parameter int UVW = UV_FRAC_BITS_DEF + 1,
	parameter int ITEM_W = 2 * ($bits(axis_geom_t) + 3 * (UV_FRAC_BITS_DEF + 1))
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	srcuv_in_if.sink         sprite,
	output logic             push_valid,
	input  wire logic        push_ready,
	output logic [ITEM_W-1:0] push_data
);
	typedef struct packed {
		axis_geom_t g;
		logic [UVW-1:0] c1;
		logic [UVW-1:0] c2;
		logic [UVW-1:0] mag;
	} axis_t;

	function automatic axis_t map_axis(input logic en, input logic signed [POS_W-1:0] pos,
		input logic [SIZE_W-1:0] size, input logic signed [POS_W-1:0] lo,
		input logic signed [POS_W-1:0] hi, input logic [UVW-1:0] c1, input logic [UVW-1:0] c2);
		logic signed [POS_W:0] pos_e, far_e, lo_e, hi_e, nl, nr, m1, m2;
		logic signed [UVW:0] span;
		axis_t a;
		pos_e = {pos[POS_W-1], pos};
		far_e = pos_e + $signed({2'b00, size});
		lo_e = {lo[POS_W-1], lo};
		hi_e = {hi[POS_W-1], hi};
		nl = (pos_e < lo_e) ? lo_e : pos_e;
		nl = (nl > hi_e) ? hi_e : nl;
		nr = (far_e < lo_e) ? lo_e : far_e;
		nr = (nr > hi_e) ? hi_e : nr;
		m1 = nl - pos_e;
		m2 = far_e - nr;
		span = $signed({1'b0, c2}) - $signed({1'b0, c1});
		a.g.neg = span[UVW];
		a.mag = span[UVW] ? UVW'(-span) : span[UVW-1:0];
		a.g.size_in = size;
		a.g.m1 = m1[SIZE_W-1:0];
		a.g.m2 = m2[SIZE_W-1:0];
		a.c1 = c1;
		a.c2 = c2;
		if (en) begin
			a.g.pos = nl[POS_W-1:0];
			a.g.size_out = OSIZE_W'(nr - nl);
			a.g.skip = (size == '0);
		end else begin
			a.g.pos = pos;
			a.g.size_out = {1'b0, size};
			a.g.skip = 1'b1;
		end
		return a;
	endfunction

	logic signed [POS_W:0] far_x, far_y;
	logic outside, keep;
	axis_t ax, ay;
	logic v_s1;
	logic [ITEM_W-1:0] d_s1;

	assign far_x = {sprite.pos_x[POS_W-1], sprite.pos_x} + $signed({2'b00, sprite.size_w});
	assign far_y = {sprite.pos_y[POS_W-1], sprite.pos_y} + $signed({2'b00, sprite.size_h});
	assign outside = (sprite.pos_x >= cfg.right)
		|| (far_x <= $signed({cfg.left[POS_W-1], cfg.left}))
		|| (sprite.pos_y >= cfg.bottom)
		|| (far_y <= $signed({cfg.top[POS_W-1], cfg.top}));
	assign keep = !cfg.enable || !outside;
	assign ax = map_axis(cfg.enable, sprite.pos_x, sprite.size_w, cfg.left, cfg.right,
		sprite.tex_u1, sprite.tex_u2);
	assign ay = map_axis(cfg.enable, sprite.pos_y, sprite.size_h, cfg.top, cfg.bottom,
		sprite.tex_v1, sprite.tex_v2);

	assign sprite.ready = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_data = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sprite.ready) begin
			v_s1 <= sprite.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (sprite.ready) begin
			d_s1 <= {ax, ay};
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/srcuv_fifo.sv */
// Short queue between the front and back stages of the clipper.
// Depends on srcuv_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module srcuv_fifo import srcuv_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != CW'(FIFO_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/srcuv_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Needs the quotient to fit QW bits; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module srcuv_div #(
	parameter int QW = 17,
	parameter int DW = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [QW+DW-1:0] num,
	input  wire logic [DW-1:0]    den,
	output logic [QW-1:0]         quo
);
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] lo_s [QW];
	logic [QW-1:0] qt_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [DW-1:0] r_in, d_in;
		logic [QW-1:0] l_in, q_in;
		logic [DW:0] t;
		logic ge;
		if (k == 0) begin : g_first
			assign r_in = num[QW+DW-1:QW];
			assign l_in = num[QW-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = lo_s[k-1];
			assign q_in = qt_s[k-1];
			assign d_in = den_s[k-1];
		end
		assign t = {r_in, l_in[QW-1]};
		assign ge = (t >= {1'b0, d_in});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
				lo_s[k] <= {l_in[QW-2:0], 1'b0};
				qt_s[k] <= {q_in[QW-2:0], ge};
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = qt_s[QW-1];
endmodule
`default_nettype wire

/* hw/rtl/srcuv_back.sv */
// Back stage: texture shift products, four pipelined dividers and the result register.
// Depends on srcuv_pkg, srcuv_if and srcuv_div; drains the queue.
`timescale 1ns / 1ps
`default_nettype none
module srcuv_back import srcuv_pkg::*; #(
	parameter int UVW = UV_FRAC_BITS_DEF + 1,
	parameter int ITEM_W = 2 * ($bits(axis_geom_t) + 3 * (UV_FRAC_BITS_DEF + 1))
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire logic [ITEM_W-1:0] pop_data,
	srcuv_out_if.source            result
);
	localparam int PW = UVW + SIZE_W;
	localparam int DW = SIZE_W + 1;

	typedef struct packed {
		axis_geom_t g;
		logic [UVW-1:0] c1;
		logic [UVW-1:0] c2;
		logic [UVW-1:0] mag;
	} axis_t;

	logic en;
	logic v_s1;
	axis_t ax_s1, ay_s1;
	logic [PW-1:0] prod_s1 [4];
	logic [UVW+DW-1:0] num [4];
	logic [DW-1:0] den [4];
	logic [UVW-1:0] quo [4];
	logic [UVW-1:0] v_pipe_s;
	axis_t ax_pipe_s [UVW];
	axis_t ay_pipe_s [UVW];
	axis_t ax_end, ay_end;
	logic out_v_q;
	logic [POS_W-1:0] x_q, y_q;
	logic [OSIZE_W-1:0] w_q, h_q;
	logic [UVW-1:0] u1_q, v1_q, u2_q, v2_q;

	assign en = !out_v_q || result.ready;
	assign pop_ready = en;

	assign den[0] = {ax_s1.g.size_in, 1'b0};
	assign den[1] = {ax_s1.g.size_in, 1'b0};
	assign den[2] = {ay_s1.g.size_in, 1'b0};
	assign den[3] = {ay_s1.g.size_in, 1'b0};

	for (genvar i = 0; i < 4; i++) begin : g_div
		assign num[i] = {prod_s1[i], 1'b0} + (UVW + DW)'(den[i][DW-1:1]);
		srcuv_div #(.QW(UVW), .DW(DW)) u_div (
			.clk(clk), .en(en), .num(num[i]), .den(den[i]), .quo(quo[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_pipe_s <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
			v_pipe_s <= {v_pipe_s[UVW-2:0], v_s1};
			out_v_q <= v_pipe_s[UVW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{ax_s1, ay_s1} <= pop_data;
			prod_s1[0] <= PW'(pop_data[ITEM_W-1-$bits(axis_geom_t)-2*UVW -: UVW]
				* pop_data[ITEM_W-1-OSIZE_W-POS_W-SIZE_W -: SIZE_W]);
			prod_s1[1] <= PW'(pop_data[ITEM_W-1-$bits(axis_geom_t)-2*UVW -: UVW]
				* pop_data[ITEM_W-1-OSIZE_W-POS_W-2*SIZE_W -: SIZE_W]);
			prod_s1[2] <= PW'(pop_data[ITEM_W/2-1-$bits(axis_geom_t)-2*UVW -: UVW]
				* pop_data[ITEM_W/2-1-OSIZE_W-POS_W-SIZE_W -: SIZE_W]);
			prod_s1[3] <= PW'(pop_data[ITEM_W/2-1-$bits(axis_geom_t)-2*UVW -: UVW]
				* pop_data[ITEM_W/2-1-OSIZE_W-POS_W-2*SIZE_W -: SIZE_W]);
			ax_pipe_s[0] <= ax_s1;
			ay_pipe_s[0] <= ay_s1;
			for (int k = 1; k < UVW; k++) begin
				ax_pipe_s[k] <= ax_pipe_s[k-1];
				ay_pipe_s[k] <= ay_pipe_s[k-1];
			end
		end
	end

	assign ax_end = ax_pipe_s[UVW-1];
	assign ay_end = ay_pipe_s[UVW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= ax_end.g.pos;
			y_q <= ay_end.g.pos;
			w_q <= ax_end.g.size_out;
			h_q <= ay_end.g.size_out;
			if (ax_end.g.skip) begin
				u1_q <= ax_end.c1;
				u2_q <= ax_end.c2;
			end else begin
				u1_q <= ax_end.g.neg ? ax_end.c1 - quo[0] : ax_end.c1 + quo[0];
				u2_q <= ax_end.g.neg ? ax_end.c2 + quo[1] : ax_end.c2 - quo[1];
			end
			if (ay_end.g.skip) begin
				v1_q <= ay_end.c1;
				v2_q <= ay_end.c2;
			end else begin
				v1_q <= ay_end.g.neg ? ay_end.c1 - quo[2] : ay_end.c1 + quo[2];
				v2_q <= ay_end.g.neg ? ay_end.c2 + quo[3] : ay_end.c2 - quo[3];
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.out_x = x_q;
	assign result.out_y = y_q;
	assign result.out_w = w_q;
	assign result.out_h = h_q;
	assign result.out_u1 = u1_q;
	assign result.out_v1 = v1_q;
	assign result.out_u2 = u2_q;
	assign result.out_v2 = v2_q;
endmodule
`default_nettype wire

/* hw/rtl/sprite_rect_clip_uv_remap.sv */
// Top level of the sprite rectangle clipper: configuration registers, front, queue and back.
// Depends on srcuv_pkg, srcuv_if, srcuv_front, srcuv_fifo and srcuv_back.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one sprite word per cycle while nothing stalls it and returns its clipped
// copy, or nothing when clipping is on and the sprite lies wholly outside the clip rectangle.
// A kept sprite passes the front register, the queue, the product register, one divider
// stage per texture coordinate bit and the result register; the sustained rate is one word
// per cycle while the result channel is ready, set by the four pipelined dividers.
module sprite_rect_clip_uv_remap import srcuv_pkg::*; #(
	parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	srcuv_in_if.sink                   sprite,
	srcuv_out_if.source                result
);
	localparam int UVW = UV_FRAC_BITS + 1;
	localparam int ITEM_W = 2 * ($bits(axis_geom_t) + 3 * UVW);

	cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	logic [ITEM_W-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.left <= '0;
			cfg_q.top <= '0;
			cfg_q.right <= 16'sh7FFF;
			cfg_q.bottom <= 16'sh7FFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CLIP_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_CLIP_LEFT:   cfg_q.left <= cfg_data;
				REG_CLIP_TOP:    cfg_q.top <= cfg_data;
				REG_CLIP_RIGHT:  cfg_q.right <= cfg_data;
				REG_CLIP_BOTTOM: cfg_q.bottom <= cfg_data;
				default: ;
			endcase
		end
	end

	srcuv_front #(.UVW(UVW), .ITEM_W(ITEM_W)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .sprite(sprite),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	srcuv_fifo #(.W(ITEM_W)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	srcuv_back #(.UVW(UVW), .ITEM_W(ITEM_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.result(result)
	);
endmodule
`default_nettype wire

/* hw/rtl/srcuv_chk.sv */
// Port checker for the sprite clipper result channel, bound to the top level.
// Depends on srcuv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module srcuv_chk import srcuv_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               valid,
	input wire logic               ready,
	input wire logic [POS_W-1:0]   out_x,
	input wire logic [OSIZE_W-1:0] out_w,
	input wire logic [OSIZE_W-1:0] out_h
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid) else $error("result word dropped while stalled");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(out_x) && $stable(out_w)) else $error("stalled word changed");
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !out_w[OSIZE_W-1]) else $error("clipped width exceeds input width range");
	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !out_h[OSIZE_W-1]) else $error("clipped height exceeds input height range");
endmodule

bind sprite_rect_clip_uv_remap srcuv_chk u_chk (
	.clk(clk), .arst_n(arst_n), .valid(result.valid), .ready(result.ready),
	.out_x(result.out_x), .out_w(result.out_w), .out_h(result.out_h)
);
`default_nettype wire

/* tb/sv/tb_sprite_rect_clip_uv_remap.sv */
// Testbench for the sprite rectangle clipper: directed and random sprites, clip settings.
// Depends on srcuv_pkg, srcuv_if and the sprite_rect_clip_uv_remap RTL.
`timescale 1ns / 1ps
module tb_sprite_rect_clip_uv_remap;
	import srcuv_pkg::*;

	localparam int UVW = UV_FRAC_BITS_DEF + 1;
	localparam int LATENCY = UV_FRAC_BITS_DEF + 5;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [UVW-1:0] u1;
		logic [UVW-1:0] v1;
		logic [UVW-1:0] u2;
		logic [UVW-1:0] v2;
	} sprite_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [OSIZE_W-1:0] w;
		logic [OSIZE_W-1:0] h;
		logic [UVW-1:0] u1;
		logic [UVW-1:0] v1;
		logic [UVW-1:0] u2;
		logic [UVW-1:0] v2;
	} clipped_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic rx_stall_on;
	longint cycles;
	int errors;

	bit en_m;
	int left_m, top_m, right_m, bottom_m;
	clipped_t clipped_q[$];

	srcuv_in_if #(.UVW(UVW)) sprite ();
	srcuv_out_if #(.UVW(UVW)) result ();

	sprite_rect_clip_uv_remap u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .sprite(sprite.sink), .result(result.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_sprite_rect_clip_uv_remap NOT OK");
			$finish;
		end
	end

	function automatic longint scaled_shift(longint span, longint moved, longint size);
		longint mag;
		longint q;
		begin
			mag = span < 0 ? -span : span;
			q = (2 * mag * moved + size) / (2 * size);
			return span < 0 ? -q : q;
		end
	endfunction

	function automatic int clamp_to(int e, int lo, int hi);
		int r;
		begin
			r = e < lo ? lo : e;
			return r > hi ? hi : r;
		end
	endfunction

	task automatic clip_axis(input int p, input int s, input int lo, input int hi,
			inout longint c1, inout longint c2, output int np, output int ns);
		int far_e;
		int ne;
		longint span;
		begin
			far_e = p + s;
			np = clamp_to(p, lo, hi);
			ne = clamp_to(far_e, lo, hi);
			ns = ne - np;
			if (s > 0) begin
				span = c2 - c1;
				c1 = c1 + scaled_shift(span, np - p, s);
				c2 = c2 - scaled_shift(span, far_e - ne, s);
			end
		end
	endtask

	task automatic predict_clip(input sprite_t s);
		int px, py, w, h, nx, ny, nw, nh;
		longint u1, v1, u2, v2;
		clipped_t c;
		begin
			px = s.x; py = s.y; w = s.w; h = s.h;
			u1 = s.u1; v1 = s.v1; u2 = s.u2; v2 = s.v2;
			nx = px; ny = py; nw = w; nh = h;
			if (en_m) begin
				if (px >= right_m || px + w <= left_m || py >= bottom_m || py + h <= top_m)
					return;
				clip_axis(px, w, left_m, right_m, u1, u2, nx, nw);
				clip_axis(py, h, top_m, bottom_m, v1, v2, ny, nh);
			end
			c.x = nx[15:0]; c.y = ny[15:0]; c.w = nw[15:0]; c.h = nh[15:0];
			c.u1 = u1[UVW-1:0]; c.v1 = v1[UVW-1:0]; c.u2 = u2[UVW-1:0]; c.v2 = v2[UVW-1:0];
			clipped_q = {clipped_q, c};
		end
	endtask

	always @(negedge clk) begin
		if (arst_n)
			result.ready <= rx_stall_on ? ($urandom_range(99) >= 35) : 1'b1;
	end

	always @(posedge clk) begin
		clipped_t e;
		if (arst_n && result.valid && result.ready) begin
			if (clipped_q.size() == 0) begin
				$error("unexpected word x=%0d", result.out_x);
				errors++;
			end else begin
				e = clipped_q.pop_front();
				if (result.out_x !== e.x) begin
					$error("out_x exp %0d got %0d", e.x, result.out_x); errors++;
				end
				if (result.out_y !== e.y) begin
					$error("out_y exp %0d got %0d", e.y, result.out_y); errors++;
				end
				if (result.out_w !== e.w) begin
					$error("out_w exp %0d got %0d", e.w, result.out_w); errors++;
				end
				if (result.out_h !== e.h) begin
					$error("out_h exp %0d got %0d", e.h, result.out_h); errors++;
				end
				if (result.out_u1 !== e.u1) begin
					$error("out_u1 exp %0d got %0d", e.u1, result.out_u1); errors++;
				end
				if (result.out_v1 !== e.v1) begin
					$error("out_v1 exp %0d got %0d", e.v1, result.out_v1); errors++;
				end
				if (result.out_u2 !== e.u2) begin
					$error("out_u2 exp %0d got %0d", e.u2, result.out_u2); errors++;
				end
				if (result.out_v2 !== e.v2) begin
					$error("out_v2 exp %0d got %0d", e.v2, result.out_v2); errors++;
				end
			end
		end
	end

	task automatic send_sprite(input sprite_t s, input bit gaps);
		begin
			if (gaps && $urandom_range(99) < 35) begin
				sprite.valid <= 1'b0;
				do @(negedge clk); while ($urandom_range(99) < 35);
			end
			sprite.valid <= 1'b1;
			sprite.pos_x <= s.x; sprite.pos_y <= s.y;
			sprite.size_w <= s.w; sprite.size_h <= s.h;
			sprite.tex_u1 <= s.u1; sprite.tex_v1 <= s.v1;
			sprite.tex_u2 <= s.u2; sprite.tex_v2 <= s.v2;
			do @(posedge clk); while (!sprite.ready);
			predict_clip(s);
			@(negedge clk);
		end
	endtask

	task automatic drain_results();
		begin
			sprite.valid <= 1'b0;
			while (clipped_q.size() != 0) @(negedge clk);
			repeat (LATENCY + 4) @(negedge clk);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		begin
			cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
			@(negedge clk);
			case (idx)
				REG_CLIP_ENABLE: en_m = val[0];
				REG_CLIP_LEFT: left_m = $signed(val);
				REG_CLIP_TOP: top_m = $signed(val);
				REG_CLIP_RIGHT: right_m = $signed(val);
				default: bottom_m = $signed(val);
			endcase
		end
	endtask

	task automatic set_clip(input bit en, input int l, input int t, input int r, input int b);
		begin
			drain_results();
			write_reg(REG_CLIP_ENABLE, {15'd0, en});
			write_reg(REG_CLIP_LEFT, l[15:0]);
			write_reg(REG_CLIP_TOP, t[15:0]);
			write_reg(REG_CLIP_RIGHT, r[15:0]);
			write_reg(REG_CLIP_BOTTOM, b[15:0]);
			cfg_we <= 1'b0;
		end
	endtask

	function automatic sprite_t make_sprite(int x, int y, int w, int h,
			int u1, int v1, int u2, int v2);
		sprite_t s;
		begin
			s.x = x[15:0]; s.y = y[15:0]; s.w = w[14:0]; s.h = h[14:0];
			s.u1 = u1[16:0]; s.v1 = v1[16:0]; s.u2 = u2[16:0]; s.v2 = v2[16:0];
			return s;
		end
	endfunction

	// Sprites mostly near the clip rectangle so that partial clips dominate.
	function automatic sprite_t random_sprite();
		sprite_t s;
		begin
			s = make_sprite(0, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(9) < 7) begin
				s.x = 16'($urandom_range(left_m + 32768, right_m + 32768) - 32768
					- $urandom_range(2000));
				s.y = 16'($urandom_range(top_m + 32768, bottom_m + 32768) - 32768
					- $urandom_range(2000));
				s.w = 15'($urandom_range(4000));
				s.h = 15'($urandom_range(4000));
				if ($urandom_range(1)) begin
					s.u1 = 17'($urandom_range(65536));
					s.u2 = 17'($urandom_range(65536));
					s.v1 = 17'($urandom_range(65536));
					s.v2 = 17'($urandom_range(65536));
				end
			end else begin
				s.x = 16'($urandom); s.y = 16'($urandom);
				s.w = 15'($urandom); s.h = 15'($urandom);
			end
			return s;
		end
	endfunction

	task automatic test_directed_pass();
		begin
			send_sprite(make_sprite(-32768, 32767, 32767, 0, 0, 65536, 65536, 0), 1'b0);
			send_sprite(make_sprite(100, -5, 0, 32767, 131071, 1, 0, 131071), 1'b0);
			send_sprite(make_sprite(32767, -32768, 32767, 32767, 65536, 0, 0, 65536), 1'b0);
		end
	endtask

	task automatic test_directed_clip();
		begin
			set_clip(1'b1, 160, 160, 1600, 960);
			send_sprite(make_sprite(0, 0, 480, 320, 0, 0, 65536, 65536), 1'b0);
			send_sprite(make_sprite(1500, 900, 480, 320, 65536, 65536, 0, 0), 1'b0);
			send_sprite(make_sprite(1600, 200, 100, 100, 0, 0, 65536, 65536), 1'b0);
			send_sprite(make_sprite(0, 200, 160, 100, 0, 0, 65536, 65536), 1'b0);
			send_sprite(make_sprite(200, 960, 100, 100, 0, 0, 65536, 65536), 1'b0);
			send_sprite(make_sprite(200, 0, 100, 160, 0, 0, 65536, 65536), 1'b0);
			send_sprite(make_sprite(0, 0, 32767, 32767, 1, 3, 131071, 99999), 1'b0);
			send_sprite(make_sprite(200, 200, 0, 0, 7, 9, 11, 13), 1'b0);
			send_sprite(make_sprite(150, 150, 3, 3, 0, 0, 1, 2), 1'b0);
			set_clip(1'b1, 1000, 1000, 200, 200);
			send_sprite(make_sprite(100, 100, 2000, 2000, 0, 0, 65536, 65536), 1'b0);
			set_clip(1'b1, -32768, -32768, 32767, 32767);
			send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 65536, 65536, 0), 1'b0);
			send_sprite(make_sprite(32766, 32766, 32767, 32767, 5, 6, 70000, 1), 1'b0);
			set_clip(1'b1, 32767, 32767, -32768, -32768);
			send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 0, 65536, 65536), 1'b0);
		end
	endtask

	task automatic test_random(input int n, input bit gaps);
		begin
			repeat (n) send_sprite(random_sprite(), gaps);
		end
	endtask

	initial begin
		cycles = 0; errors = 0; rx_stall_on = 1'b0;
		en_m = 1'b0; left_m = 0; top_m = 0; right_m = 32767; bottom_m = 32767;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_idx = REG_CLIP_ENABLE; cfg_data = '0;
		sprite.valid = 1'b0; result.ready = 1'b0;
		sprite.pos_x = '0; sprite.pos_y = '0; sprite.size_w = '0; sprite.size_h = '0;
		sprite.tex_u1 = '0; sprite.tex_v1 = '0; sprite.tex_u2 = '0; sprite.tex_v2 = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_pass();
		test_directed_clip();
		rx_stall_on = 1'b1;
		set_clip(1'b0, 0, 0, 32767, 32767);
		test_random(250, 1'b1);
		set_clip(1'b1, -1600, -800, 4800, 3200);
		test_random(300, 1'b1);
		rx_stall_on = 1'b0;
		test_random(300, 1'b0);
		rx_stall_on = 1'b1;
		set_clip(1'b1, 0, 0, 32767, 32767);
		test_random(300, 1'b1);
		set_clip(1'b1, -32768, -32768, 32767, 32767);
		test_random(200, 1'b1);
		set_clip(1'b1, 16'sh7000, -200, 16'sh7ff0, 100);
		test_random(200, 1'b1);
		set_clip(1'b1, $urandom_range(2000), $urandom_range(2000),
			2000 + $urandom_range(6000), 2000 + $urandom_range(6000));
		test_random(200, 1'b1);
		drain_results();
		if (errors == 0)
			$display("tb_sprite_rect_clip_uv_remap OK");
		else
			$display("tb_sprite_rect_clip_uv_remap NOT OK");
		$finish;
	end
endmodule
